/* rtl/core/fqdr_pkg.sv */
// Shared types and codes for the unique-key FIFO queue core.
// No dependencies; imported by fqdr_cell and the top level.
`timescale 1ns / 1ps

package fqdr_pkg;

   localparam int KEY_W    = 31;
   localparam int AMOUNT_W = 32;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_DUP   = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic shift;     // take the entry of the next cell (pop at head)
      logic load;      // write the pending item (this cell is the tail)
      logic occupied;  // cell holds a queued entry
   } cell_ctrl_type;

   // duplicate probe travelling along the chain
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic             hit;
   } probe_type;

endpackage : fqdr_pkg

/* rtl/core/fqdr_cell.sv */
// One queue slot of the shifting FIFO chain, with its stage of the key probe.
// Depends on fqdr_pkg.
`timescale 1ns / 1ps

module fqdr_cell import fqdr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cell_ctrl_type              ctrl,
   input  logic [KEY_W-1:0]           nbr_key,
   input  logic signed [AMOUNT_W-1:0] nbr_amount,
   input  logic [KEY_W-1:0]           new_key,
   input  logic signed [AMOUNT_W-1:0] new_amount,
   input  probe_type                  probe_i,
   output logic [KEY_W-1:0]           key_o,
   output logic signed [AMOUNT_W-1:0] amount_o,
   output probe_type                  probe_o
);

   logic [KEY_W-1:0]           key_ff;
   logic signed [AMOUNT_W-1:0] amount_ff;
   logic                       probe_valid_ff;
   logic [KEY_W-1:0]           probe_key_ff;
   logic                       probe_hit_ff;

   // slot payload: no reset
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         key_ff    <= nbr_key;
         amount_ff <= nbr_amount;
      end else if (ctrl.load) begin
         key_ff    <= new_key;
         amount_ff <= new_amount;
      end
      probe_key_ff <= probe_i.key;
      probe_hit_ff <= probe_i.hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_valid_ff <= 1'b0;
      end else begin
         probe_valid_ff <= probe_i.valid;
      end
   end

   assign key_o          = key_ff;
   assign amount_o       = amount_ff;
   assign probe_o.valid  = probe_valid_ff;
   assign probe_o.key    = probe_key_ff;
   assign probe_o.hit    = probe_hit_ff
                         | (probe_valid_ff & ctrl.occupied & (key_ff == probe_key_ff));

endmodule : fqdr_cell

/* rtl/core/fifo_queue_with_duplicate_key_reject_core.sv */
// Top level of the unique-key FIFO queue: sequencer plus a chain of fqdr_cell slots.
// Depends on fqdr_pkg and fqdr_cell.
`timescale 1ns / 1ps

// Usage
//  Input: present req_opcode/req_key/req_amount with start; the item is taken at a
//  rising edge with start high and busy low. Insert (OP_INSERT) appends at the tail,
//  remove (OP_REMOVE) pops the oldest entry.
//  Output: one result per item, shown for exactly one cycle with rsp_strobe high.
//  rsp_status gives ok, duplicate, full or empty; rsp_out_key/rsp_out_amount carry the
//  popped entry on a good remove, else zero; head key, head valid and entry count
//  show the queue after the item.
//  Storage: slot 0 is always the head. A pop shifts every slot one place towards
//  the head together; an insert writes the slot at index entry_count.
//  Duplicate check: the key travels down the chain one cell per cycle, each cell
//  comparing it with its own entry, so an insert into a non-full queue keeps busy
//  high until the probe leaves the last cell; the result is then registered, and
//  the entry is written into the tail slot if no cell found the key.
//  Remove, and insert into a full queue, do not scan: the result appears in the
//  cycle after acceptance and a new item may be taken in that same cycle.
//  Reset empties the queue (count zero) and drops any item in flight; slot contents
//  are not cleared. The receiver cannot stall: results are never held back.

module fifo_queue_with_duplicate_key_reject_core import fqdr_pkg::*; #(
   parameter int  QUEUE_DEPTH = 16,
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_opcode,
   input  logic [KEY_W-1:0]           req_key,
   input  logic signed [AMOUNT_W-1:0] req_amount,
   output logic                       rsp_strobe,
   output logic [1:0]                 rsp_status,
   output logic [KEY_W-1:0]           rsp_out_key,
   output logic signed [AMOUNT_W-1:0] rsp_out_amount,
   output logic [KEY_W-1:0]           rsp_head_key,
   output logic                       rsp_head_valid,
   output logic [CNT_W-1:0]           rsp_entry_count
);

   typedef enum logic {
      IDLE,
      SCAN
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [KEY_W-1:0]           pend_key_ff;
   logic signed [AMOUNT_W-1:0] pend_amount_ff;

   logic                       rsp_strobe_ff, rsp_strobe_in;
   status_type                 rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]           rsp_out_key_ff, rsp_out_key_in;
   logic signed [AMOUNT_W-1:0] rsp_out_amount_ff, rsp_out_amount_in;
   logic [KEY_W-1:0]           rsp_head_key_ff, rsp_head_key_in;
   logic                       rsp_head_valid_ff, rsp_head_valid_in;

   logic accept, is_remove, full, empty;
   logic launch, scan_done, scan_hit, commit_ins, commit_rem;

   // chain wiring
   logic [KEY_W-1:0]           key_chain    [QUEUE_DEPTH];
   logic signed [AMOUNT_W-1:0] amount_chain [QUEUE_DEPTH];
   probe_type                  probe_link   [QUEUE_DEPTH+1];
   cell_ctrl_type              cell_ctrl    [QUEUE_DEPTH];

   assign busy      = (state_ff == SCAN);
   assign accept    = start & ~busy;
   assign is_remove = (req_opcode == OP_REMOVE);
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);

   // an insert into a non-full queue starts the probe walk
   assign launch     = accept & ~is_remove & ~full;
   assign scan_done  = (state_ff == SCAN) & probe_link[QUEUE_DEPTH].valid;
   assign scan_hit   = probe_link[QUEUE_DEPTH].hit;
   assign commit_ins = scan_done & ~scan_hit;
   assign commit_rem = accept & is_remove & ~empty;

   assign probe_link[0].valid = launch;
   assign probe_link[0].key   = req_key;
   assign probe_link[0].hit   = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [KEY_W-1:0]           nbr_key;
      logic signed [AMOUNT_W-1:0] nbr_amount;

      if (i == QUEUE_DEPTH - 1) begin : g_last
         // last slot refills with its own data; only reachable as unoccupied
         assign nbr_key    = key_chain[i];
         assign nbr_amount = amount_chain[i];
      end else begin : g_mid
         assign nbr_key    = key_chain[i+1];
         assign nbr_amount = amount_chain[i+1];
      end

      assign cell_ctrl[i].shift    = commit_rem;
      assign cell_ctrl[i].load     = commit_ins & (count_ff == CNT_W'(i));
      assign cell_ctrl[i].occupied = (count_ff > CNT_W'(i));

      fqdr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl[i]),
         .nbr_key    (nbr_key),
         .nbr_amount (nbr_amount),
         .new_key    (pend_key_ff),
         .new_amount (pend_amount_ff),
         .probe_i    (probe_link[i]),
         .key_o      (key_chain[i]),
         .amount_o   (amount_chain[i]),
         .probe_o    (probe_link[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      if (launch) begin
         state_in = SCAN;
      end else if (scan_done) begin
         state_in = IDLE;
      end

      count_in = count_ff;
      if (commit_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (commit_rem) begin
         count_in = count_ff - CNT_W'(1);
      end

      rsp_strobe_in = (accept & ~launch) | scan_done;

      if (scan_done) begin
         rsp_status_in = scan_hit ? ST_DUP : ST_OK;
      end else if (is_remove) begin
         rsp_status_in = empty ? ST_EMPTY : ST_OK;
      end else begin
         rsp_status_in = ST_FULL;
      end

      rsp_out_key_in    = commit_rem ? key_chain[0]    : '0;
      rsp_out_amount_in = commit_rem ? amount_chain[0] : '0;

      // head after the item
      if (commit_rem) begin
         rsp_head_key_in = (count_ff > CNT_W'(1)) ? key_chain[1] : '0;
      end else if (commit_ins) begin
         rsp_head_key_in = empty ? pend_key_ff : key_chain[0];
      end else begin
         rsp_head_key_in = empty ? '0 : key_chain[0];
      end
      rsp_head_valid_in = (count_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      if (launch) begin
         pend_key_ff    <= req_key;
         pend_amount_ff <= req_amount;
      end
      rsp_status_ff     <= rsp_status_in;
      rsp_out_key_ff    <= rsp_out_key_in;
      rsp_out_amount_ff <= rsp_out_amount_in;
      rsp_head_key_ff   <= rsp_head_key_in;
      rsp_head_valid_ff <= rsp_head_valid_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_key     = rsp_out_key_ff;
   assign rsp_out_amount  = rsp_out_amount_ff;
   assign rsp_head_key    = rsp_head_key_ff;
   assign rsp_head_valid  = rsp_head_valid_ff;
   assign rsp_entry_count = count_ff;

   // occupancy stays within the chain
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   // no result may surface while a probe is still walking
   a_quiet_scan : assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN) |-> !rsp_strobe_ff)
      else $error("result strobe during probe walk");

   // the count only moves together with a good result
   a_count_move : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |-> (rsp_strobe_ff && rsp_status_ff == ST_OK))
      else $error("entry count changed without a good result");

   // head flag agrees with the reported count
   a_head_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (rsp_head_valid_ff == (count_ff != '0)))
      else $error("head valid disagrees with entry count");

   // an empty status only comes from an empty queue
   a_empty_status : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_status_ff == ST_EMPTY) |-> (count_ff == '0))
      else $error("empty status with queued entries");

endmodule : fifo_queue_with_duplicate_key_reject_core
